[src/min_heap_priority_queue_unit_macros.svh]
// assertion macros shared by the heap checker
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mhpq_pkg.sv]
// shared types, codes and defaults of the min-heap priority queue
package mhpq_pkg;

  localparam int HEAP_DEPTH_DEF = 128;
  localparam int ID_COUNT_DEF   = 1024;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 10;
  localparam int COST_W = 15;
  localparam int ST_W   = 2;
  localparam int FILL_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [COST_W-1:0] cost;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[src/mhpq_ram.sv]
// single write port, single read port ram with registered read data
module mhpq_ram
  import mhpq_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = HEAP_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/min_heap_priority_queue_unit.sv]
// top level of the min-heap priority queue with decrease-key
// Binary min-heap of (id, cost) words held in one single-port-pair ram; every
// command returns one result word with a status and the fill after it. All work
// goes through that ram, one read and at most one write a cycle. Push climbs
// from the new last slot, reading the parent and moving it down while the new
// cost is smaller; pop reads the root and the last entry, walks the hole down the
// smaller child, then lets the last entry climb back; decrease-key scans one slot
// a cycle from the root, then climbs from the match, or reports an absent id.
// The block takes a new word only when idle, in the cycle after the result is
// loaded; a finished result waits in the output register until taken.
module min_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int ID_COUNT   = ID_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ID_W-1:0]   in_item_id,
  input  logic [COST_W-1:0] in_item_cost,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_id,
  output logic [COST_W-1:0] out_cost,
  output logic [ST_W-1:0]   out_status,
  output logic [FILL_W-1:0] out_fill
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = AW + 2;
  localparam int MOD_STEPS = (ID_COUNT >= 2**ID_W) ? 0 : ID_W - $clog2(ID_COUNT) + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SU_RD    = 4'd1;
  localparam logic [3:0] S_SU_CMP   = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_POP_ROOT = 4'd4;
  localparam logic [3:0] S_POP_LAST = 4'd5;
  localparam logic [3:0] S_POP_LOAD = 4'd6;
  localparam logic [3:0] S_DN_CHK   = 4'd7;
  localparam logic [3:0] S_DN_LEFT  = 4'd8;
  localparam logic [3:0] S_DN_SEL   = 4'd9;
  localparam logic [3:0] S_DN_ONE   = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  // control
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     h_r, h_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [AW-1:0]     chk_addr_r, chk_addr_nxt;
  entry_t            right_r, right_nxt;
  entry_t            res_r, res_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [COST_W-1:0] out_cost_r, out_cost_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd;

  logic [ID_W-1:0]          id_mod;
  logic [AW-1:0]            par;
  logic [KW-1:0]            km1;
  logic [KW-1:0]            m_ext;
  logic [AW-1:0]            cidx;
  entry_t                   chosen;
  logic [FILL_W+CW-1:0]     fill_ext;

  mhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // id reduced modulo ID_COUNT by shifted compare-subtract steps
  always_comb begin
    id_mod = in_item_id;
    for (int s = MOD_STEPS - 1; s >= 0; s--) begin
      if (32'(id_mod) >= (32'(ID_COUNT) << s)) begin
        id_mod = id_mod - ID_W'(32'(ID_COUNT) << s);
      end
    end
  end

  assign par      = (pos_r - AW'(1)) >> 1;
  assign km1      = k_r - KW'(1);
  assign m_ext    = KW'(count_r);
  assign fill_ext = {{FILL_W{1'b0}}, count_r};

  // smaller child, right one on a tie
  always_comb begin
    if (right_r.cost > rd.cost) begin
      chosen = rd;
      cidx   = km1[AW-1:0];
    end else begin
      chosen = right_r;
      cidx   = k_r[AW-1:0];
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    chk_vld_nxt    = chk_vld_r;
    out_valid_nxt  = out_valid_r;
    id_nxt         = id_r;
    cost_nxt       = cost_r;
    pos_nxt        = pos_r;
    h_nxt          = h_r;
    k_nxt          = k_r;
    chk_addr_nxt   = chk_addr_r;
    right_nxt      = right_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    out_id_nxt     = out_id_r;
    out_cost_nxt   = out_cost_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = {id_r, cost_r};
    ram_raddr      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt   = id_mod;
          cost_nxt = in_item_cost;
          res_nxt  = '0;
          st_nxt   = ST_OK;
          case (in_cmd)
            CMD_PUSH: begin
              if (count_r >= CW'(HEAP_DEPTH)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                pos_nxt   = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                state_nxt = S_SU_RD;
              end
            end
            CMD_DEC: begin
              scan_nxt    = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            CMD_POP: begin
              if (count_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP_ROOT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SU_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = par;
          state_nxt = S_SU_CMP;
        end
      end

      S_SU_CMP: begin
        ram_we = 1'b1;
        if (cost_r < rd.cost) begin
          ram_wdata = rd;
          pos_nxt   = par;
          state_nxt = S_SU_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // one slot issued per cycle, compared in the next cycle
      S_SCAN: begin
        if (chk_vld_r && (rd.id == id_r)) begin
          pos_nxt     = chk_addr_r;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_SU_RD;
        end else if (scan_r < count_r) begin
          ram_raddr    = scan_r[AW-1:0];
          chk_vld_nxt  = 1'b1;
          chk_addr_nxt = scan_r[AW-1:0];
          scan_nxt     = scan_r + CW'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          st_nxt      = ST_NOTFOUND;
          state_nxt   = S_DONE;
        end
      end

      S_POP_ROOT: begin
        ram_raddr = '0;
        state_nxt = S_POP_LAST;
      end

      S_POP_LAST: begin
        ram_raddr = count_r[AW-1:0];
        res_nxt   = rd;
        state_nxt = S_POP_LOAD;
      end

      S_POP_LOAD: begin
        id_nxt    = rd.id;
        cost_nxt  = rd.cost;
        h_nxt     = '0;
        k_nxt     = KW'(2);
        state_nxt = S_DN_CHK;
      end

      S_DN_CHK: begin
        if (k_r < m_ext) begin
          ram_raddr = k_r[AW-1:0];
          state_nxt = S_DN_LEFT;
        end else if (k_r == m_ext) begin
          ram_raddr = km1[AW-1:0];
          state_nxt = S_DN_ONE;
        end else begin
          pos_nxt   = h_r;
          state_nxt = S_SU_RD;
        end
      end

      S_DN_LEFT: begin
        right_nxt = rd;
        ram_raddr = km1[AW-1:0];
        state_nxt = S_DN_SEL;
      end

      S_DN_SEL: begin
        ram_we    = 1'b1;
        ram_waddr = h_r;
        ram_wdata = chosen;
        h_nxt     = cidx;
        k_nxt     = KW'({cidx, 1'b0}) + KW'(2);
        state_nxt = S_DN_CHK;
      end

      // only a left child remains below the hole
      S_DN_ONE: begin
        ram_we    = 1'b1;
        ram_waddr = h_r;
        ram_wdata = rd;
        pos_nxt   = km1[AW-1:0];
        state_nxt = S_SU_RD;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = res_r.id;
          out_cost_nxt   = res_r.cost;
          out_status_nxt = st_r;
          out_fill_nxt   = fill_ext[FILL_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    cost_r       <= cost_nxt;
    pos_r        <= pos_nxt;
    h_r          <= h_nxt;
    k_r          <= k_nxt;
    chk_addr_r   <= chk_addr_nxt;
    right_r      <= right_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    out_id_r     <= out_id_nxt;
    out_cost_r   <= out_cost_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_cost   = out_cost_r;
  assign out_status = out_status_r;
  assign out_fill   = out_fill_r;

endmodule

[src/mhpq_checker.sv]
// port-level checker of the min-heap priority queue and its bind
`include "min_heap_priority_queue_unit_macros.svh"

module mhpq_checker
  import mhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ID_W-1:0]   out_id,
  input logic [COST_W-1:0] out_cost,
  input logic [ST_W-1:0]   out_status,
  input logic [FILL_W-1:0] out_fill
);

  // a command keeps the unit busy for at least the next cycle
  `MHPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // only a successful pop carries an id and cost
  `MHPQ_ASSERT_NOW(a_zero_payload, out_valid && (out_status != ST_OK), (out_id == '0) && (out_cost == '0), "payload on non-ok status")

  `MHPQ_ASSERT_NOW(a_empty_fill, out_valid && (out_status == ST_EMPTY), out_fill == '0, "empty status with nonzero fill")

  `MHPQ_ASSERT_NOW(a_fill_bound, out_valid, (HEAP_DEPTH >= 2**FILL_W) || (int'(out_fill) <= HEAP_DEPTH), "fill above depth")

  // a stalled result word holds
  `MHPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_id) && $stable(out_cost) && $stable(out_status) && $stable(out_fill), "result word changed while stalled")

endmodule

bind min_heap_priority_queue_unit mhpq_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_mhpq_checker (.*);

[tb/sv/tb_min_heap_priority_queue_unit.sv]
// self-checking testbench of the min-heap priority queue with decrease-key
module tb_min_heap_priority_queue_unit
  import mhpq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH = HEAP_DEPTH_DEF;
  localparam int ID_COUNT   = ID_COUNT_DEF;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int RECENT_N    = 64;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [COST_W-1:0] cost;
    bit                drain_first;
  } heap_word_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [COST_W-1:0] cost;
    logic [ST_W-1:0]   status;
    logic [FILL_W-1:0] fill;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd = CMD_NOP;
  logic [ID_W-1:0] in_item_id = '0;
  logic [COST_W-1:0] in_item_cost = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] out_id;
  logic [COST_W-1:0] out_cost;
  logic [ST_W-1:0] out_status;
  logic [FILL_W-1:0] out_fill;

  heap_word_t   word_pending_q[$];
  heap_result_t result_due_q[$];
  int           fail_count = 0;

  // shadow heap
  logic [ID_W-1:0]   shadow_ids[HEAP_DEPTH];
  logic [COST_W-1:0] shadow_costs[HEAP_DEPTH];
  int                shadow_count = 0;

  // ids pushed lately, so decrease-key mostly hits
  logic [ID_W-1:0] recent_ids[RECENT_N];
  int              recent_n = 0;

  always #1 clk = ~clk;

  min_heap_priority_queue_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_item_id  (in_item_id),
    .in_item_cost(in_item_cost),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_id      (out_id),
    .out_cost    (out_cost),
    .out_status  (out_status),
    .out_fill    (out_fill)
  );

  function automatic void shadow_sift_up(int pos, logic [ID_W-1:0] id,
                                         logic [COST_W-1:0] cost);
    int par;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (cost < shadow_costs[par]) begin
        shadow_ids[pos] = shadow_ids[par];
        shadow_costs[pos] = shadow_costs[par];
        pos = par;
      end else begin
        break;
      end
    end
    shadow_ids[pos] = id;
    shadow_costs[pos] = cost;
  endfunction

  // apply one command to the shadow heap and queue the result it must give
  function automatic void apply_heap_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id_in,
                                         logic [COST_W-1:0] cost);
    heap_result_t r;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] last_id;
    logic [COST_W-1:0] last_cost;
    int h;
    int k;
    int m;
    id = ID_W'(id_in % ID_COUNT);
    r.id = '0;
    r.cost = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_count++;
          shadow_sift_up(shadow_count - 1, id, cost);
        end
      end
      CMD_DEC: begin
        h = 0;
        while (h < shadow_count && shadow_ids[h] != id) h++;
        if (h >= shadow_count) r.status = ST_NOTFOUND;
        else shadow_sift_up(h, id, cost);
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id = shadow_ids[0];
          r.cost = shadow_costs[0];
          last_id = shadow_ids[shadow_count - 1];
          last_cost = shadow_costs[shadow_count - 1];
          shadow_count--;
          m = shadow_count;
          h = 0;
          k = 2;
          // hole walks down the smaller child, right child wins a tie
          while (k < m) begin
            if (shadow_costs[k] > shadow_costs[k - 1]) k--;
            shadow_ids[h] = shadow_ids[k];
            shadow_costs[h] = shadow_costs[k];
            h = k;
            k = k * 2 + 2;
          end
          if (k == m) begin
            shadow_ids[h] = shadow_ids[k - 1];
            shadow_costs[h] = shadow_costs[k - 1];
            h = k - 1;
          end
          shadow_sift_up(h, last_id, last_cost);
        end
      end
      default: ;
    endcase
    r.fill = FILL_W'(shadow_count);
    result_due_q.push_back(r);
  endfunction

  function automatic void add_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                   logic [COST_W-1:0] cost, bit drain_first);
    heap_word_t w;
    w.cmd = cmd;
    w.id = id;
    w.cost = cost;
    w.drain_first = drain_first;
    word_pending_q.push_back(w);
  endfunction

  // extremes and small ranges for ties, otherwise anything
  function automatic logic [COST_W-1:0] rand_cost();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel <= 4) return COST_W'($urandom_range(0, 15));
    return COST_W'($urandom_range(0, 32767));
  endfunction

  function automatic void add_phase(int count, int push_pct, int pop_pct, int dec_pct);
    int roll;
    logic [ID_W-1:0] id;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        if ($urandom_range(0, 9) < 3) id = ID_W'($urandom_range(0, 31));
        else id = ID_W'($urandom_range(0, 1023));
        recent_ids[recent_n % RECENT_N] = id;
        recent_n++;
        add_word(CMD_PUSH, id, rand_cost(), i == 0);
      end else if (roll < push_pct + pop_pct) begin
        add_word(CMD_POP, ID_W'($urandom_range(0, 1023)), rand_cost(), i == 0);
      end else if (roll < push_pct + pop_pct + dec_pct) begin
        if (recent_n != 0 && $urandom_range(0, 9) < 8)
          id = recent_ids[$urandom_range(0, (recent_n < RECENT_N ? recent_n : RECENT_N) - 1)];
        else
          id = ID_W'($urandom_range(0, 1023));
        add_word(CMD_DEC, id, rand_cost(), i == 0);
      end else begin
        add_word(CMD_NOP, ID_W'($urandom_range(0, 1023)), rand_cost(), i == 0);
      end
    end
  endfunction

  // sender: bursts of words separated by random gaps
  always @(posedge clk) begin : drive_words
    heap_word_t w;
    int gap_left;
    int burst_left;
    bit holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      holding = in_valid && !in_ready;
      if (in_valid && in_ready) apply_heap_cmd(in_cmd, in_item_id, in_item_cost);
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_pending_q.size() != 0 &&
                     !(word_pending_q[0].drain_first && result_due_q.size() != 0)) begin
          w = word_pending_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= w.cmd;
          in_item_id <= w.id;
          in_item_cost <= w.cost;
          if (burst_left <= 1) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: calm windows alternate with short and long stalls
  always @(posedge clk) begin : observe_results
    heap_result_t r;
    int stall_left;
    int cycle_ctr;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      cycle_ctr = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_due_q.size() == 0) begin
          $error("result word with none expected: id %0d cost %0d status %0d fill %0d",
                 out_id, out_cost, out_status, out_fill);
          fail_count++;
        end else begin
          r = result_due_q.pop_front();
          if (out_id !== r.id) begin
            $error("out_id: expected %0d, got %0d", r.id, out_id);
            fail_count++;
          end
          if (out_cost !== r.cost) begin
            $error("out_cost: expected %0d, got %0d", r.cost, out_cost);
            fail_count++;
          end
          if (out_status !== r.status) begin
            $error("out_status: expected %0d, got %0d", r.status, out_status);
            fail_count++;
          end
          if (out_fill !== r.fill) begin
            $error("out_fill: expected %0d, got %0d", r.fill, out_fill);
            fail_count++;
          end
        end
      end
      cycle_ctr++;
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (((cycle_ctr >> 8) & 3) != 0 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, ((cycle_ctr >> 9) & 1) ? 30 : 4);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    // empty heap corners and the unused command code
    add_word(CMD_POP, 10'd1023, 15'd32767, 1'b0);
    add_word(CMD_DEC, 10'd0, 15'd0, 1'b0);
    add_word(CMD_NOP, 10'd1023, 15'd32767, 1'b0);
    // extremes, duplicate ids and equal costs
    add_word(CMD_PUSH, 10'd1023, 15'd32767, 1'b0);
    add_word(CMD_PUSH, 10'd0, 15'd0, 1'b0);
    add_word(CMD_PUSH, 10'd5, 15'd100, 1'b0);
    add_word(CMD_PUSH, 10'd5, 15'd100, 1'b0);
    add_word(CMD_PUSH, 10'd682, 15'd100, 1'b0);
    add_word(CMD_PUSH, 10'd341, 15'd100, 1'b0);
    // duplicate id hits the lowest slot; a raised cost only climbs
    add_word(CMD_DEC, 10'd5, 15'd50, 1'b0);
    add_word(CMD_DEC, 10'd682, 15'd32767, 1'b0);
    add_word(CMD_DEC, 10'd999, 15'd1, 1'b0);
    add_word(CMD_NOP, 10'd0, 15'd0, 1'b0);
    for (int i = 0; i < 7; i++) add_word(CMD_POP, 10'd0, 15'd0, 1'b0);
    // fill to the top, churn, then drain past empty, twice
    for (int rep = 0; rep < 2; rep++) begin
      add_phase(170, 85, 5, 8);
      add_phase(70, 40, 40, 15);
      add_phase(180, 5, 85, 8);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (word_pending_q.size() != 0 || in_valid) @(negedge clk);
    while (result_due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
